// ----- design/irnpc_pkg.sv -----
// Shared types and constants for the IR nibble pulse-count transmitter.
package irnpc_pkg;

  localparam int TIME_WIDTH = 20;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [3:0] NIBBLE_MASK = 4'hf;

  localparam logic [TIME_WIDTH-1:0] PAUSE_RESET = TIME_WIDTH'(600);
  localparam logic [TIME_WIDTH-1:0] FRAME_RESET = TIME_WIDTH'(1200);
  localparam logic [TIME_WIDTH-1:0] DATA_RESET  = TIME_WIDTH'(600);

  // Configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PAUSE = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAME = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DATA  = 2'd2;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_STOP  = 2'd2
  } pulse_kind_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic emitter_on;
    logic busy_res;
    logic load_rejected;
  } out_item_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] pause_ticks;
    logic [TIME_WIDTH-1:0] frame_pulse_ticks;
    logic [TIME_WIDTH-1:0] data_pulse_ticks;
  } cfg_regs_t;

endpackage

// ----- design/irnpc_cfg.sv -----
// Configuration register file for the IR nibble pulse-count transmitter.
module irnpc_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [irnpc_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
  input  logic [irnpc_pkg::TIME_WIDTH-1:0]      wr_data,
  output irnpc_pkg::cfg_regs_t                  regs
);
  import irnpc_pkg::*;

  cfg_regs_t regs_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q.pause_ticks       <= PAUSE_RESET;
      regs_q.frame_pulse_ticks <= FRAME_RESET;
      regs_q.data_pulse_ticks  <= DATA_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_PAUSE: regs_q.pause_ticks       <= wr_data;
        REG_FRAME: regs_q.frame_pulse_ticks <= wr_data;
        REG_DATA:  regs_q.data_pulse_ticks  <= wr_data;
        default: ; // unknown index: write dropped
      endcase
    end
  end

  assign regs = regs_q;

endmodule

// ----- design/irnpc_core.sv -----
// Transmit sequencer: pulse state registers and per-item next-state logic.
module irnpc_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  irnpc_pkg::in_item_t  item,
  input  irnpc_pkg::cfg_regs_t cfg,
  output irnpc_pkg::out_item_t result
);
  import irnpc_pkg::*;

  logic [7:0]            shift_byte, shift_byte_next;
  logic                  low_nibble_phase, low_nibble_phase_next;
  logic [3:0]            pulses_left, pulses_left_next;
  pulse_kind_t           pulse_kind, pulse_kind_next;
  logic                  in_on_period, in_on_period_next;
  logic [TIME_WIDTH-1:0] tick_counter, tick_counter_next;
  logic                  active, active_next;
  logic                  rejected;

  logic [TIME_WIDTH-1:0] dur;
  logic [TIME_WIDTH-1:0] phase_len;
  logic [TIME_WIDTH-1:0] count_inc;
  logic                  phase_done;

  // Length of the current phase; zero acts as one
  always_comb begin
    if (!in_on_period) begin
      dur = cfg.pause_ticks;
    end else if (pulse_kind == KIND_DATA) begin
      dur = cfg.data_pulse_ticks;
    end else begin
      dur = cfg.frame_pulse_ticks;
    end
    phase_len = (dur == '0) ? TIME_WIDTH'(1) : dur;
  end

  assign count_inc  = tick_counter + TIME_WIDTH'(1);
  assign phase_done = (count_inc >= phase_len) || (count_inc == '0);

  // Next state
  always_comb begin
    shift_byte_next       = shift_byte;
    low_nibble_phase_next = low_nibble_phase;
    pulses_left_next      = pulses_left;
    pulse_kind_next       = pulse_kind;
    in_on_period_next     = in_on_period;
    tick_counter_next     = tick_counter;
    active_next           = active;
    rejected              = 1'b0;

    if (item.cmd == CMD_LOAD) begin
      if (active) begin
        rejected = 1'b1;
      end else begin
        shift_byte_next       = item.data_byte;
        low_nibble_phase_next = 1'b0;
        pulses_left_next      = item.data_byte[7:4];
        pulse_kind_next       = KIND_START;
        in_on_period_next     = 1'b0;
        tick_counter_next     = '0;
        active_next           = 1'b1;
      end
    end else if (active) begin
      if (!phase_done) begin
        tick_counter_next = count_inc;
      end else begin
        tick_counter_next = '0;
        if (!in_on_period) begin
          in_on_period_next = 1'b1;
        end else begin
          in_on_period_next = 1'b0;
          case (pulse_kind)
            KIND_START: begin
              pulse_kind_next = (pulses_left != 4'd0) ? KIND_DATA : KIND_STOP;
            end
            KIND_DATA: begin
              pulses_left_next = (pulses_left - 4'd1) & NIBBLE_MASK;
              if (pulses_left_next == 4'd0) begin
                pulse_kind_next = KIND_STOP;
              end
            end
            default: begin // stop pulse ends the nibble
              if (!low_nibble_phase) begin
                low_nibble_phase_next = 1'b1;
                pulses_left_next      = shift_byte[3:0] & NIBBLE_MASK;
                pulse_kind_next       = KIND_START;
              end else begin
                active_next           = 1'b0;
                pulse_kind_next       = KIND_START;
                low_nibble_phase_next = 1'b0;
              end
            end
          endcase
        end
      end
    end
  end

  // Result reflects state after this item
  always_comb begin
    result.emitter_on    = active_next && in_on_period_next;
    result.busy_res      = active_next;
    result.load_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte       <= '0;
      low_nibble_phase <= 1'b0;
      pulses_left      <= '0;
      pulse_kind       <= KIND_START;
      in_on_period     <= 1'b0;
      tick_counter     <= '0;
      active           <= 1'b0;
    end else if (step) begin
      shift_byte       <= shift_byte_next;
      low_nibble_phase <= low_nibble_phase_next;
      pulses_left      <= pulses_left_next;
      pulse_kind       <= pulse_kind_next;
      in_on_period     <= in_on_period_next;
      tick_counter     <= tick_counter_next;
      active           <= active_next;
    end
  end

endmodule

// ----- design/ir_nibble_pulse_count_transmitter.sv -----
// Top level of the IR nibble pulse-count transmitter.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------
//   in      | input     | in_valid / in_stall   | in_item  (cmd, data_byte)
//   out     | output    | out_valid / out_stall | out_item (emitter_on,
//           |           |                       |   busy_res, load_rejected)
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low. The item lands in the
// input register, the sequencer updates its state as the item moves into the
// output register, and the result is offered from there.
// rst is synchronous: sequencer idle, config back to 600/1200/600 ticks.
// A stalled output holds its result; the input register keeps taking items
// as long as the output register can drain, so in_stall only rises when
// both stages are full and out_stall is high.
module ir_nibble_pulse_count_transmitter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  irnpc_pkg::in_item_t                  in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output irnpc_pkg::out_item_t                 out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [irnpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [irnpc_pkg::TIME_WIDTH-1:0]      cfg_data
);
  import irnpc_pkg::*;

  // Input register stage
  logic      s1_valid;
  in_item_t  s1_item;
  // Output register stage
  logic      s2_valid;
  out_item_t s2_item;

  logic      s2_load;   // s1 item moves into the output register this cycle
  logic      s1_load;   // new item accepted this cycle
  cfg_regs_t cfg;
  out_item_t core_result;

  assign s2_load  = s1_valid && !(s2_valid && out_stall);
  assign in_stall = s1_valid && !s2_load;
  assign s1_load  = in_valid && !in_stall;

  // Config writes always accepted, so user must issue them only while idle.
  assign cfg_ready = 1'b1;

  irnpc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg)
  );

  // Sequencer state advances exactly once per item, on its move to stage 2
  irnpc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (s2_load),
    .item   (s1_item),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (!out_stall) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_item <= core_result;
    end
  end

  assign out_valid = s2_valid;
  assign out_item  = s2_item;

endmodule

// ----- sim/tb.sv -----
// Self-checking bench for the IR nibble pulse-count transmitter: directed table, then random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import irnpc_pkg::*;

  // Index 2'd3 decodes to no register; the write is dropped.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

  localparam int unsigned TARGET_ITEMS   = 950;
  localparam int unsigned LONG_HOLD      = 300;  // receiver hold-off, cycles
  localparam int unsigned HOLD_BURST     = 40;   // back-to-back items offered meanwhile
  localparam int unsigned DRAIN_CYCLES   = 10;   // idle wait after the last result
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  // Results that the directed table can state outright.
  localparam out_item_t IDLE_RES     = '{1'b0, 1'b0, 1'b0};  // emitter off, not busy
  localparam out_item_t OFF_BUSY     = '{1'b0, 1'b1, 1'b0};  // in a pause
  localparam out_item_t REJECTED_RES = '{1'b0, 1'b1, 1'b1};  // load during a pause

  localparam in_item_t TICK_ITEM = '{CMD_TICK, 8'h00};

  typedef enum logic [1:0] {
    ROW_ITEM,   // offer one item
    ROW_CFG,    // wait for quiet, then write a register
    ROW_FLUSH   // tick until the byte in flight is done
  } row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_INDEX_WIDTH-1:0] reg_idx;
    logic [TIME_WIDTH-1:0]      reg_val;
    in_item_t                   item;
    logic                       pinned;  // want holds the result; else predicted
    out_item_t                  want;
  } plan_row_t;

  localparam int PLAN_ROWS = 29;

  // Directed part. Starts on reset timing (600/1200/600 ticks), takes pause and
  // data to zero (acts as one tick) and frame to one, and each to full scale.
  // Full-scale phases are cut short by a rewrite while the byte is in flight.
  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_ITEM,  REG_PAUSE,  20'h0,     TICK_ITEM,          1'b1, IDLE_RES},     // tick, idle
    '{ROW_ITEM,  REG_PAUSE,  20'h0,     '{CMD_LOAD, 8'h00}, 1'b1, OFF_BUSY},     // empty nibbles
    '{ROW_ITEM,  REG_PAUSE,  20'h0,     '{CMD_LOAD, 8'hFF}, 1'b1, REJECTED_RES}, // load on busy
    '{ROW_ITEM,  REG_PAUSE,  20'h0,     TICK_ITEM,          1'b1, OFF_BUSY},
    '{ROW_CFG,   REG_PAUSE,  20'h0,     TICK_ITEM,          1'b0, IDLE_RES},     // zero -> 1
    '{ROW_CFG,   REG_FRAME,  20'h1,     TICK_ITEM,          1'b0, IDLE_RES},
    '{ROW_CFG,   REG_DATA,   20'hFFFFF, TICK_ITEM,          1'b0, IDLE_RES},     // unused by 00
    '{ROW_CFG,   REG_UNUSED, 20'hFFFFF, TICK_ITEM,          1'b0, IDLE_RES},     // dropped
    '{ROW_FLUSH, REG_PAUSE,  20'h0,     TICK_ITEM,          1'b0, IDLE_RES},
    '{ROW_ITEM,  REG_PAUSE,  20'h0,     TICK_ITEM,          1'b1, IDLE_RES},
    '{ROW_CFG,   REG_DATA,   20'h0,     TICK_ITEM,          1'b0, IDLE_RES},
    '{ROW_ITEM,  REG_PAUSE,  20'h0,     '{CMD_LOAD, 8'hFF}, 1'b1, OFF_BUSY},     // full nibbles
    '{ROW_ITEM,  REG_PAUSE,  20'h0,     TICK_ITEM,          1'b0, IDLE_RES},
    '{ROW_ITEM,  REG_PAUSE,  20'h0,     '{CMD_LOAD, 8'h00}, 1'b0, IDLE_RES},     // reject, on
    '{ROW_FLUSH, REG_PAUSE,  20'h0,     TICK_ITEM,          1'b0, IDLE_RES},
    '{ROW_CFG,   REG_PAUSE,  20'hFFFFF, TICK_ITEM,          1'b0, IDLE_RES},
    '{ROW_ITEM,  REG_PAUSE,  20'h0,     '{CMD_LOAD, 8'h81}, 1'b1, OFF_BUSY},
    '{ROW_ITEM,  REG_PAUSE,  20'h0,     TICK_ITEM,          1'b1, OFF_BUSY},
    '{ROW_CFG,   REG_PAUSE,  20'h2,     TICK_ITEM,          1'b0, IDLE_RES},     // cuts pause
    '{ROW_FLUSH, REG_PAUSE,  20'h0,     TICK_ITEM,          1'b0, IDLE_RES},
    '{ROW_CFG,   REG_FRAME,  20'hFFFFF, TICK_ITEM,          1'b0, IDLE_RES},
    '{ROW_ITEM,  REG_PAUSE,  20'h0,     '{CMD_LOAD, 8'h18}, 1'b1, OFF_BUSY},
    '{ROW_ITEM,  REG_PAUSE,  20'h0,     TICK_ITEM,          1'b0, IDLE_RES},
    '{ROW_ITEM,  REG_PAUSE,  20'h0,     TICK_ITEM,          1'b0, IDLE_RES},     // start on
    '{ROW_CFG,   REG_FRAME,  20'h3,     TICK_ITEM,          1'b0, IDLE_RES},     // cuts pulse
    '{ROW_FLUSH, REG_PAUSE,  20'h0,     TICK_ITEM,          1'b0, IDLE_RES},
    '{ROW_ITEM,  REG_PAUSE,  20'h0,     '{CMD_LOAD, 8'h7E}, 1'b1, OFF_BUSY},
    '{ROW_FLUSH, REG_PAUSE,  20'h0,     TICK_ITEM,          1'b0, IDLE_RES},
    '{ROW_ITEM,  REG_PAUSE,  20'h0,     TICK_ITEM,          1'b1, IDLE_RES}      // idle again
  };

  // DUT ports; every input known from time zero.
  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  in_item_t                   in_item   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  out_item_t                  out_item;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [TIME_WIDTH-1:0]      cfg_data  = '0;

  // Predictor copy of the registers and sequencer.
  logic [TIME_WIDTH-1:0] cfg_pause = PAUSE_RESET;
  logic [TIME_WIDTH-1:0] cfg_frame = FRAME_RESET;
  logic [TIME_WIDTH-1:0] cfg_data_len = DATA_RESET;
  logic [7:0]            sq_byte   = '0;
  logic                  sq_low    = 1'b0;   // sending the low nibble
  logic [3:0]            sq_left   = '0;     // data pulses still to send
  pulse_kind_t           sq_kind   = KIND_START;
  logic                  sq_on     = 1'b0;   // emitter-on part of the pulse
  logic [TIME_WIDTH-1:0] sq_count  = '0;
  logic                  sq_active = 1'b0;

  out_item_t   pending_levels [$];  // expected results, oldest first
  int unsigned mismatches   = 0;
  int unsigned worked_items = 0;    // items the block acted on
  int unsigned quiet_cycles = 0;
  int unsigned burst_left   = 0;    // sender offers back to back while nonzero
  logic        calm         = 1'b0; // both sides run without idling
  logic        long_hold    = 1'b0; // sender asks the receiver for a long hold-off

  ir_nibble_pulse_count_transmitter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Advance the predicted transmitter by one item and return its result.
  // A phase of length D ends on its D-th tick; the next phase's level shows
  // on that same tick. Zero lengths count as one tick.
  function automatic out_item_t step_waveform(input in_item_t it);
    out_item_t             r;
    logic [TIME_WIDTH-1:0] len;
    logic [TIME_WIDTH-1:0] nxt;
    r = '0;
    if (it.cmd == CMD_LOAD) begin
      if (sq_active) begin
        r.load_rejected = 1'b1;  // dropped, no tick passes
      end else begin
        sq_byte   = it.data_byte;
        sq_low    = 1'b0;
        sq_left   = it.data_byte[7:4];
        sq_kind   = KIND_START;
        sq_on     = 1'b0;
        sq_count  = '0;
        sq_active = 1'b1;
      end
    end else if (sq_active) begin
      if (!sq_on) len = cfg_pause;
      else if (sq_kind == KIND_DATA) len = cfg_data_len;
      else len = cfg_frame;
      if (len == '0) len = TIME_WIDTH'(1);
      nxt = sq_count + 1'b1;
      if (nxt >= len || nxt == '0) begin
        sq_count = '0;
        if (!sq_on) begin
          sq_on = 1'b1;
        end else begin
          sq_on = 1'b0;
          case (sq_kind)
            KIND_START: sq_kind = (sq_left != 4'd0) ? KIND_DATA : KIND_STOP;
            KIND_DATA: begin
              sq_left = sq_left - 4'd1;
              if (sq_left == 4'd0) sq_kind = KIND_STOP;
            end
            default: begin
              // stop pulse: move to the low nibble, or finish the byte
              if (!sq_low) begin
                sq_low  = 1'b1;
                sq_left = sq_byte[3:0] & NIBBLE_MASK;
                sq_kind = KIND_START;
              end else begin
                sq_active = 1'b0;
                sq_kind   = KIND_START;
                sq_low    = 1'b0;
              end
            end
          endcase
        end
      end else begin
        sq_count = nxt;
      end
    end
    r.emitter_on = sq_active & sq_on;
    r.busy_res   = sq_active;
    return r;
  endfunction

  // Offer one item after a random gap and wait until it is taken. in_valid
  // is left high so a following item with no gap goes out back to back;
  // any caller that stops sending lowers it in the same step.
  task automatic offer_item(input in_item_t it, input logic pinned, input out_item_t want);
    int unsigned gap;
    out_item_t   got;
    if (calm || burst_left != 0) gap = 0;
    else gap = $urandom_range(0, 13);
    if (burst_left != 0) burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    if (it.cmd == CMD_LOAD || sq_active) worked_items++;
    got = step_waveform(it);
    pending_levels.push_back(pinned ? want : got);
  endtask

  task automatic offer_random(input logic load);
    in_item_t it;
    it.cmd       = load ? CMD_LOAD : CMD_TICK;
    it.data_byte = 8'($urandom_range(0, 255));  // ticks carry junk data
    offer_item(it, 1'b0, '0);
  endtask

  // Tick until the predicted byte is fully sent.
  task automatic run_out_byte();
    while (sq_active) offer_random(1'b0);
  endtask

  // Stop sending and let every expected result come back.
  task automatic await_results();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [TIME_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PAUSE: cfg_pause    = val;
      REG_FRAME: cfg_frame    = val;
      REG_DATA:  cfg_data_len = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Mostly one- and two-tick phases so many bytes fit in the run.
  function automatic logic [TIME_WIDTH-1:0] pick_len();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll <= 5) return TIME_WIDTH'(1);
    if (roll <= 8) return TIME_WIDTH'($urandom_range(2, 4));
    return TIME_WIDTH'($urandom_range(5, 30));
  endfunction

  // Stimulus
  initial begin : stimulus
    logic first;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      case (plan[i].kind)
        ROW_ITEM: offer_item(plan[i].item, plan[i].pinned, plan[i].want);
        ROW_CFG: begin
          await_results();
          write_reg(plan[i].reg_idx, plan[i].reg_val);
        end
        default: run_out_byte();
      endcase
    end

    // Random part: bytes with random timing, rejected loads sprinkled in,
    // some broken sequences, new timing now and then.
    first = 1'b1;
    while (worked_items < TARGET_ITEMS) begin
      if (first || $urandom_range(0, 2) == 0) begin
        // pause until everything is back, then retime
        await_results();
        write_reg(REG_PAUSE, pick_len());
        write_reg(REG_FRAME, pick_len());
        write_reg(REG_DATA, pick_len());
        calm = ($urandom_range(0, 3) == 0);
        if (first) begin
          // receiver holds off while the sender keeps offering: fills the block
          calm       = 1'b0;
          long_hold  = 1'b1;
          burst_left = HOLD_BURST;
          first      = 1'b0;
        end
      end
      offer_random(1'b1);
      if ($urandom_range(0, 4) == 0) begin
        // broken: a retry load lands somewhere in the byte, or just after it
        repeat ($urandom_range(0, 20)) offer_random(1'b0);
        offer_random(1'b1);
      end
      while (sq_active) offer_random($urandom_range(0, 15) == 0);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) offer_random(1'b0);  // idle ticks
      end
    end

    await_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ir_nibble_pulse_count_transmitter verification clean");
    end else begin
      $display("ir_nibble_pulse_count_transmitter verification failed");
    end
    $finish;
  end

  // Receiver: random hold-off before each result, none when calm, one long
  // hold when the sender asks for it.
  initial begin : receiver
    int unsigned hold;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        hold      = LONG_HOLD;
        long_hold = 1'b0;
      end else if (calm) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 13);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare every taken result with the oldest expectation.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %b", $time, out_item);
        mismatches++;
      end else begin
        want = pending_levels.pop_front();
        if (out_item.emitter_on !== want.emitter_on) begin
          $display("%0t: emitter_on expected %b actual %b",
                   $time, want.emitter_on, out_item.emitter_on);
          mismatches++;
        end
        if (out_item.busy_res !== want.busy_res) begin
          $display("%0t: busy_res expected %b actual %b",
                   $time, want.busy_res, out_item.busy_res);
          mismatches++;
        end
        if (out_item.load_rejected !== want.load_rejected) begin
          $display("%0t: load_rejected expected %b actual %b",
                   $time, want.load_rejected, out_item.load_rejected);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long with no handshake on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ir_nibble_pulse_count_transmitter verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- files.f -----
design/irnpc_pkg.sv
design/irnpc_cfg.sv
design/irnpc_core.sv
design/ir_nibble_pulse_count_transmitter.sv
sim/tb.sv
